// ===== rtl/ddm_pkg.sv =====
// Shared codes and constants for the differential-drive mixer with heading hold.
`default_nettype none
package ddm_pkg;

  // Motion command codes.
  localparam logic [3:0] ACT_FWD        = 4'd0;
  localparam logic [3:0] ACT_BACK       = 4'd1;
  localparam logic [3:0] ACT_LEFT       = 4'd2;
  localparam logic [3:0] ACT_RIGHT      = 4'd3;
  localparam logic [3:0] ACT_LEFT_FWD   = 4'd4;
  localparam logic [3:0] ACT_LEFT_BACK  = 4'd5;
  localparam logic [3:0] ACT_RIGHT_FWD  = 4'd6;
  localparam logic [3:0] ACT_RIGHT_BACK = 4'd7;
  localparam logic [3:0] ACT_STOP       = 4'd8;

  // Motor direction codes.
  localparam logic [1:0] DIR_OFF  = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRACE_MODE  = 2'd0;
  localparam logic [1:0] REG_GAIN        = 2'd1;
  localparam logic [1:0] REG_UPPER_LIMIT = 2'd2;

  // Direction record codes.
  localparam logic [3:0] REC_NONE    = 4'd0;
  localparam logic [3:0] REC_UNKNOWN = 4'd10;
  localparam logic [6:0] NO_RECORD   = 7'd110;

  localparam logic [7:0] MIN_SPEED   = 8'd10;
  localparam logic [7:0] GAIN_RESET  = 8'd2;
  localparam logic [7:0] LIMIT_RESET = 8'd180;

  typedef struct packed {
    logic [1:0] dir_a;
    logic [7:0] speed_a;
    logic [1:0] dir_b;
    logic [7:0] speed_b;
  } motor_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/diff_drive_mixer_heading_hold.sv =====
// Top level: two-motor mixer with proportional heading hold for forward and backward.
// An accepted word is loaded into the input register at the accepting edge. Its result word
// goes into the result register once that register is empty or being read out, and is then on
// the out channel. The multiply-and-clamp pass sits between the two registers.
// Throughput: one word per cycle; in_ready is low only while both registers hold a word and
// out_ready is low. Reset (rst_n low, synchronous): pipeline emptied, trace_mode 0, gain 2,
// upper_limit 180, direction record 0, latched record NO_RECORD, reference heading 0.
`default_nettype none
module diff_drive_mixer_heading_hold (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [3:0]  in_action,
  input  wire         [7:0]  in_speed,
  input  wire signed  [12:0] in_heading,
  input  wire                in_on_ground,
  output logic               out_valid,
  input  wire                out_ready,
  output logic        [1:0]  out_dir_a,
  output logic        [7:0]  out_speed_a,
  output logic        [1:0]  out_dir_b,
  output logic        [7:0]  out_speed_b,
  input  wire                cfg_we,
  input  wire         [1:0]  cfg_index,
  input  wire         [7:0]  cfg_data
);

  // Configuration registers.
  logic       trace_mode_r;
  logic [7:0] gain_r;
  logic [7:0] upper_limit_r;

  // Heading-hold state.
  logic [3:0]         dir_rec_r, dir_rec_nxt;
  logic [6:0]         latched_rec_r, latched_rec_nxt;
  logic signed [12:0] ref_heading_r, ref_heading_nxt;

  // Input stage.
  logic               s1_valid_r;
  logic [3:0]         s1_action_r;
  logic [7:0]         s1_speed_r;
  logic signed [12:0] s1_heading_r;
  logic               s1_on_ground_r;
  logic               s1_adv;

  // Result stage.
  logic                    out_valid_r;
  ddm_pkg::motor_cmd_t     out_cmd_r, cmd_nxt;

  // Datapath.
  logic               capture;
  logic signed [12:0] ref_used;
  logic signed [13:0] err;
  logic signed [22:0] prod;
  logic signed [22:0] speed16;
  logic [7:0]         side_right, side_left, half;

  function automatic logic [7:0] clamp_side(input logic signed [22:0] t,
                                            input logic [7:0] upper);
    logic signed [22:0] tb;
    logic signed [18:0] v;
    // Add 15 to negative values so the shift truncates toward zero.
    tb = t + (t[22] ? 23'sd15 : 23'sd0);
    v  = tb[22:4];
    if (v > $signed({11'b0, upper})) begin
      clamp_side = upper;
    end else if (v < $signed({11'b0, ddm_pkg::MIN_SPEED})) begin
      clamp_side = ddm_pkg::MIN_SPEED;
    end else begin
      clamp_side = v[7:0];
    end
  endfunction

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  // The capture decision sees the record left by the previous command.
  assign capture    = (latched_rec_r != {3'b0, dir_rec_r}) || !s1_on_ground_r;
  assign ref_used   = capture ? s1_heading_r : ref_heading_r;
  assign err        = 14'(s1_heading_r) - 14'(ref_used);
  assign prod       = err * $signed({1'b0, gain_r});
  assign speed16    = $signed({11'b0, s1_speed_r, 4'b0});
  assign side_right = clamp_side(speed16 + prod, upper_limit_r);
  assign side_left  = clamp_side(speed16 - prod, upper_limit_r);
  assign half       = {1'b0, s1_speed_r[7:1]};

  always_comb begin
    dir_rec_nxt     = dir_rec_r;
    latched_rec_nxt = latched_rec_r;
    ref_heading_nxt = ref_heading_r;
    cmd_nxt         = '{ddm_pkg::DIR_OFF, 8'd0, ddm_pkg::DIR_OFF, 8'd0};
    unique case (s1_action_r)
      ddm_pkg::ACT_FWD, ddm_pkg::ACT_BACK: begin
        if (trace_mode_r) begin
          if (s1_action_r == ddm_pkg::ACT_FWD) begin
            cmd_nxt = '{ddm_pkg::DIR_FWD, s1_speed_r, ddm_pkg::DIR_FWD, s1_speed_r};
          end else begin
            cmd_nxt = '{ddm_pkg::DIR_BACK, s1_speed_r, ddm_pkg::DIR_BACK, s1_speed_r};
          end
        end else begin
          if (capture) begin
            latched_rec_nxt = {3'b0, dir_rec_r};
            ref_heading_nxt = s1_heading_r;
          end
          if (s1_action_r == ddm_pkg::ACT_FWD) begin
            cmd_nxt = '{ddm_pkg::DIR_FWD, side_right, ddm_pkg::DIR_FWD, side_left};
          end else begin
            cmd_nxt = '{ddm_pkg::DIR_BACK, side_left, ddm_pkg::DIR_BACK, side_right};
          end
          dir_rec_nxt = s1_action_r + 4'd1;
        end
      end
      ddm_pkg::ACT_LEFT: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_FWD, s1_speed_r, ddm_pkg::DIR_BACK, s1_speed_r};
      end
      ddm_pkg::ACT_RIGHT: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_BACK, s1_speed_r, ddm_pkg::DIR_FWD, s1_speed_r};
      end
      ddm_pkg::ACT_LEFT_FWD: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_FWD, s1_speed_r, ddm_pkg::DIR_FWD, half};
      end
      ddm_pkg::ACT_LEFT_BACK: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_BACK, s1_speed_r, ddm_pkg::DIR_BACK, half};
      end
      ddm_pkg::ACT_RIGHT_FWD: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_FWD, half, ddm_pkg::DIR_FWD, s1_speed_r};
      end
      ddm_pkg::ACT_RIGHT_BACK: begin
        dir_rec_nxt = s1_action_r + 4'd1;
        cmd_nxt     = '{ddm_pkg::DIR_BACK, half, ddm_pkg::DIR_BACK, s1_speed_r};
      end
      ddm_pkg::ACT_STOP: begin
        dir_rec_nxt = s1_action_r + 4'd1;
      end
      default: begin
        dir_rec_nxt = ddm_pkg::REC_UNKNOWN;
      end
    endcase
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_mode_r  <= 1'b0;
      gain_r        <= ddm_pkg::GAIN_RESET;
      upper_limit_r <= ddm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddm_pkg::REG_TRACE_MODE:  trace_mode_r  <= cfg_data[0];
        ddm_pkg::REG_GAIN:        gain_r        <= cfg_data;
        ddm_pkg::REG_UPPER_LIMIT: upper_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control and heading-hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      dir_rec_r     <= ddm_pkg::REC_NONE;
      latched_rec_r <= ddm_pkg::NO_RECORD;
      ref_heading_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s1_adv) begin
        dir_rec_r     <= dir_rec_nxt;
        latched_rec_r <= latched_rec_nxt;
        ref_heading_r <= ref_heading_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r    <= in_action;
      s1_speed_r     <= in_speed;
      s1_heading_r   <= in_heading;
      s1_on_ground_r <= in_on_ground;
    end
    if (s1_valid_r && s1_adv) begin
      out_cmd_r <= cmd_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dir_a   = out_cmd_r.dir_a;
  assign out_speed_a = out_cmd_r.speed_a;
  assign out_dir_b   = out_cmd_r.dir_b;
  assign out_speed_b = out_cmd_r.speed_b;

  // A motor that is off always has zero speed, and both motors stop together.
  a_off_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r.dir_a == ddm_pkg::DIR_OFF |->
      out_cmd_r.speed_a == 8'd0 && out_cmd_r.dir_b == ddm_pkg::DIR_OFF &&
      out_cmd_r.speed_b == 8'd0)
    else $error("motor off with nonzero speed or unpaired");

  // The latched record is either the reset marker or a real record code.
  a_latched_code: assert property (@(posedge clk) disable iff (!rst_n)
    latched_rec_r == ddm_pkg::NO_RECORD || latched_rec_r <= {3'b0, ddm_pkg::REC_UNKNOWN})
    else $error("latched record out of range");

  // A word held in the input stage stays put while the result register is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_action_r) && $stable(s1_speed_r))
    else $error("input stage lost a word under stall");

  // State changes only when a word moves to the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_adv) |=> $stable(dir_rec_r) && $stable(ref_heading_r))
    else $error("heading state changed without a word");

endmodule
`default_nettype wire

// ===== bench/ddm_mixer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the motor mixer: predicts each motor command word and compares it on the out channel.
module ddm_mixer_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire         [3:0]  in_action,
  input  wire         [7:0]  in_speed,
  input  wire signed  [12:0] in_heading,
  input  wire                in_on_ground,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire         [1:0]  out_dir_a,
  input  wire         [7:0]  out_speed_a,
  input  wire         [1:0]  out_dir_b,
  input  wire         [7:0]  out_speed_b,
  input  wire                cfg_we,
  input  wire         [1:0]  cfg_index,
  input  wire         [7:0]  cfg_data,
  output int                 fail_count,
  output int                 pending
);

  // Copy of the configuration registers.
  logic       trace_on;
  logic [7:0] hold_gain;
  logic [7:0] speed_cap;

  // Copy of the heading-hold state.
  logic [3:0] last_cmd_rec;
  logic [6:0] locked_rec;
  int         hold_ref;

  ddm_pkg::motor_cmd_t motor_cmd_q[$];
  ddm_pkg::motor_cmd_t want;
  int         mismatches = 0;
  int         waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic ddm_pkg::motor_cmd_t pack_cmd(input logic [1:0] da, input logic [7:0] sa,
                                                   input logic [1:0] db, input logic [7:0] sb);
    ddm_pkg::motor_cmd_t c;
    c.dir_a   = da;
    c.speed_a = sa;
    c.dir_b   = db;
    c.speed_b = sb;
    return c;
  endfunction

  // Truncate toward zero to whole speed units, then cap at the limit or lift to the floor.
  function automatic logic [7:0] limit_side(input int scaled);
    int v;
    v = scaled / 16;
    if (v > int'(speed_cap)) return speed_cap;
    if (v < int'(ddm_pkg::MIN_SPEED)) return ddm_pkg::MIN_SPEED;
    return v[7:0];
  endfunction

  function automatic ddm_pkg::motor_cmd_t mix_command(input logic [3:0] act,
                                                      input logic [7:0] spd,
                                                      input logic signed [12:0] hdg,
                                                      input logic grounded);
    ddm_pkg::motor_cmd_t c;
    logic [7:0] half_spd;
    logic [7:0] side_right;
    logic [7:0] side_left;
    logic [1:0] dir;
    int         err;
    half_spd = spd >> 1;
    c = pack_cmd(ddm_pkg::DIR_OFF, 8'd0, ddm_pkg::DIR_OFF, 8'd0);
    case (act)
      ddm_pkg::ACT_FWD, ddm_pkg::ACT_BACK: begin
        dir = (act == ddm_pkg::ACT_FWD) ? ddm_pkg::DIR_FWD : ddm_pkg::DIR_BACK;
        if (trace_on) begin
          c = pack_cmd(dir, spd, dir, spd);
        end else begin
          // The record compared here was left by the previous command.
          if (locked_rec != {3'b000, last_cmd_rec} || !grounded) begin
            locked_rec = {3'b000, last_cmd_rec};
            hold_ref   = int'(hdg);
          end
          err        = (int'(hdg) - hold_ref) * int'(hold_gain);
          side_right = limit_side(err + 16 * int'(spd));
          side_left  = limit_side(16 * int'(spd) - err);
          if (act == ddm_pkg::ACT_FWD)
            c = pack_cmd(ddm_pkg::DIR_FWD, side_right, ddm_pkg::DIR_FWD, side_left);
          else
            c = pack_cmd(ddm_pkg::DIR_BACK, side_left, ddm_pkg::DIR_BACK, side_right);
        end
      end
      ddm_pkg::ACT_LEFT:
        c = pack_cmd(ddm_pkg::DIR_FWD, spd, ddm_pkg::DIR_BACK, spd);
      ddm_pkg::ACT_RIGHT:
        c = pack_cmd(ddm_pkg::DIR_BACK, spd, ddm_pkg::DIR_FWD, spd);
      ddm_pkg::ACT_LEFT_FWD:
        c = pack_cmd(ddm_pkg::DIR_FWD, spd, ddm_pkg::DIR_FWD, half_spd);
      ddm_pkg::ACT_LEFT_BACK:
        c = pack_cmd(ddm_pkg::DIR_BACK, spd, ddm_pkg::DIR_BACK, half_spd);
      ddm_pkg::ACT_RIGHT_FWD:
        c = pack_cmd(ddm_pkg::DIR_FWD, half_spd, ddm_pkg::DIR_FWD, spd);
      ddm_pkg::ACT_RIGHT_BACK:
        c = pack_cmd(ddm_pkg::DIR_BACK, half_spd, ddm_pkg::DIR_BACK, spd);
      default:
        c = pack_cmd(ddm_pkg::DIR_OFF, 8'd0, ddm_pkg::DIR_OFF, 8'd0);
    endcase
    // Open-loop forward and backward leave the record alone.
    if (!(trace_on && (act == ddm_pkg::ACT_FWD || act == ddm_pkg::ACT_BACK)))
      last_cmd_rec = (act > ddm_pkg::ACT_STOP) ? ddm_pkg::REC_UNKNOWN : act + 4'd1;
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      trace_on     = 1'b0;
      hold_gain    = ddm_pkg::GAIN_RESET;
      speed_cap    = ddm_pkg::LIMIT_RESET;
      last_cmd_rec = ddm_pkg::REC_NONE;
      locked_rec   = ddm_pkg::NO_RECORD;
      hold_ref     = 0;
      motor_cmd_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ddm_pkg::REG_TRACE_MODE:  trace_on  = cfg_data[0];
          ddm_pkg::REG_GAIN:        hold_gain = cfg_data;
          ddm_pkg::REG_UPPER_LIMIT: speed_cap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        motor_cmd_q.push_back(mix_command(in_action, in_speed, in_heading, in_on_ground));
      if (out_valid && out_ready) begin
        if (motor_cmd_q.size() == 0) begin
          report_mismatch("result word with no command outstanding");
        end else begin
          want = motor_cmd_q.pop_front();
          if (out_dir_a !== want.dir_a)
            report_mismatch($sformatf("dir_a got %0d expected %0d", out_dir_a, want.dir_a));
          if (out_speed_a !== want.speed_a)
            report_mismatch($sformatf("speed_a got %0d expected %0d",
                                      out_speed_a, want.speed_a));
          if (out_dir_b !== want.dir_b)
            report_mismatch($sformatf("dir_b got %0d expected %0d", out_dir_b, want.dir_b));
          if (out_speed_b !== want.speed_b)
            report_mismatch($sformatf("speed_b got %0d expected %0d",
                                      out_speed_b, want.speed_b));
        end
      end
    end
    waiting <= motor_cmd_q.size();
  end

endmodule

// ===== bench/tb_diff_drive_mixer_heading_hold.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, command stimulus, configuration phases and the final verdict.
module tb_diff_drive_mixer_heading_hold;

  localparam logic [3:0] ACT_FIRST_UNKNOWN = ddm_pkg::ACT_STOP + 4'd1;
  localparam logic [3:0] ACT_LAST_UNKNOWN  = 4'hF;
  localparam int         PHASES            = 8;
  localparam int         WORDS_PER_PHASE   = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [3:0]  in_action = '0;
  logic        [7:0]  in_speed = '0;
  logic signed [12:0] in_heading = '0;
  logic               in_on_ground = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [1:0]  out_dir_a;
  logic        [7:0]  out_speed_a;
  logic        [1:0]  out_dir_b;
  logic        [7:0]  out_speed_b;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = '0;
  logic        [7:0]  cfg_data = '0;
  int                 fail_count;
  int                 pending;

  // Stimulus control shared by the two sides.
  logic calm = 1'b0;
  logic idle_on = 1'b1;
  int   words_sent = 0;
  int   yaw = 0;
  int   stall_left = 0;

  diff_drive_mixer_heading_hold u_dut (.*);
  ddm_mixer_checker u_checker (.*);

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: back-pressure in short random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!calm && idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
    out_ready <= (stall_left == 0);
  end

  task automatic send_word(input logic [3:0] act, input logic [7:0] spd, input int hdg,
                           input logic gnd);
    if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_speed     <= spd;
    in_heading   <= 13'(hdg);
    in_on_ground <= gnd;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    // Switch idling on and off now and then so that long clean stretches occur too.
    if (words_sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic trace, input logic [7:0] gain, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= ddm_pkg::REG_TRACE_MODE;
    cfg_data  <= {7'd0, trace};
    @(posedge clk);
    cfg_index <= ddm_pkg::REG_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_index <= ddm_pkg::REG_UPPER_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_speed();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly runs of forward or backward with a drifting heading, some turns, some noise.
  task automatic random_burst();
    int         kind;
    int         run_len;
    logic [7:0] base_spd;
    logic [3:0] act;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      act = $urandom_range(0, 1) ? ddm_pkg::ACT_BACK : ddm_pkg::ACT_FWD;
      if ($urandom_range(0, 2) == 0)
        send_word(4'($urandom_range(ddm_pkg::ACT_LEFT, ddm_pkg::ACT_STOP)), pick_speed(),
                  yaw, 1'b1);
      run_len  = $urandom_range(3, 12);
      base_spd = pick_speed();
      repeat (run_len) begin
        yaw = yaw + int'($urandom_range(0, 48)) - 24;
        if (yaw > 4095) yaw = 4095;
        if (yaw < -4096) yaw = -4096;
        if ($urandom_range(0, 3) == 0) base_spd = pick_speed();
        send_word(act, base_spd, yaw, $urandom_range(0, 15) != 0);
      end
    end else if (kind == 7 || kind == 8) begin
      send_word(4'($urandom_range(ddm_pkg::ACT_LEFT, ddm_pkg::ACT_STOP)), pick_speed(), yaw,
                1'($urandom_range(0, 1)));
    end else begin
      if ($urandom_range(0, 1) == 0) yaw = int'($urandom_range(0, 5759)) - 2880;
      send_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                int'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int phase;
    int first_word;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on reset values. The first two forward words both capture the reference,
    // since the record seen by the capture lags one command.
    send_word(ddm_pkg::ACT_FWD, 8'd100, 0, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd100, 160, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd100, 320, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd255, 2879, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd0, -2880, 1'b1);
    send_word(ddm_pkg::ACT_BACK, 8'd255, -4096, 1'b1);
    send_word(ddm_pkg::ACT_BACK, 8'd0, 4095, 1'b1);
    send_word(ddm_pkg::ACT_BACK, 8'd128, 4095, 1'b1);
    send_word(ddm_pkg::ACT_BACK, 8'd128, -4096, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd50, 100, 1'b0);
    send_word(ddm_pkg::ACT_FWD, 8'd50, 900, 1'b0);
    send_word(ddm_pkg::ACT_FWD, 8'd50, 900, 1'b1);
    send_word(ddm_pkg::ACT_LEFT, 8'd255, 0, 1'b1);
    send_word(ddm_pkg::ACT_RIGHT, 8'd0, 0, 1'b1);
    send_word(ddm_pkg::ACT_LEFT_FWD, 8'd255, 0, 1'b1);
    send_word(ddm_pkg::ACT_LEFT_BACK, 8'd1, 0, 1'b1);
    send_word(ddm_pkg::ACT_RIGHT_FWD, 8'd254, 0, 1'b1);
    send_word(ddm_pkg::ACT_RIGHT_BACK, 8'd255, 0, 1'b1);
    send_word(ddm_pkg::ACT_STOP, 8'd255, 0, 1'b1);
    send_word(ACT_FIRST_UNKNOWN, 8'd255, 4095, 1'b1);
    send_word(ACT_LAST_UNKNOWN, 8'd255, -4096, 1'b0);
    send_word(ddm_pkg::ACT_FWD, 8'd200, -1000, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd200, -1200, 1'b1);
    send_word(ddm_pkg::ACT_FWD, 8'd200, -1600, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // The block must be empty before any register changes.
        wait_drained();
        case (phase)
          1: set_config(1'b0, 8'd255, 8'd255);
          2: set_config(1'b0, 8'd0, 8'd0);
          3: set_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          4: set_config(1'b0, 8'($urandom_range(1, 8)), 8'd5);
          5: set_config(1'b1, 8'd255, 8'd0);
          default: set_config(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
      end
      if (phase == PHASES - 1) calm = 1'b1;
      first_word = words_sent;
      while (words_sent - first_word < WORDS_PER_PHASE) random_burst();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
